// ===== rtl/guid_text_parser_top_assert.svh =====
// ----------------------------------------------------------------------------
// guid text parser assertion macros
// concurrent checks that vanish in synthesis builds
// ----------------------------------------------------------------------------
`ifndef GUID_TEXT_PARSER_TOP_ASSERT_SVH
`define GUID_TEXT_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define GTP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define GTP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GTP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GTP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define GTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/gtp_pkg.sv =====
// ----------------------------------------------------------------------------
// gtp_pkg
// layout codes, character constants and template lookups for the parser
// ----------------------------------------------------------------------------
package gtp_pkg;

    localparam int unsigned NUM_LAYOUTS = 6;

    localparam logic [6:0] POS_SAT      = 7'd69;
    localparam logic [6:0] LEN_DIGITS   = 7'd32;
    localparam logic [6:0] LEN_HYPHENS  = 7'd36;
    localparam logic [6:0] LEN_BRACED   = 7'd38;
    localparam logic [6:0] LEN_HEXVALS  = 7'd68;
    localparam logic [6:0] LEN_WORDS    = 7'd35;

    // template marker for a hex digit slot
    localparam logic [7:0] C_HEX    = 8'h68;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_HYPHEN = 8'h2D;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_X      = 8'h78;

    typedef enum logic [2:0] {
        L_DIGITS  = 3'd0,
        L_HYPHENS = 3'd1,
        L_BRACES  = 3'd2,
        L_PARENS  = 3'd3,
        L_HEXVALS = 3'd4,
        L_WORDS   = 3'd5
    } t_layout;

    typedef logic [NUM_LAYOUTS-1:0] t_layout_mask;
    typedef logic [127:0]           t_acc;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    // only meaningful when is_hex holds
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        hex_val = c[6] ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

    function automatic logic [6:0] tpl_len(input t_layout k);
        case (k)
            L_DIGITS:  tpl_len = LEN_DIGITS;
            L_HYPHENS: tpl_len = LEN_HYPHENS;
            L_BRACES:  tpl_len = LEN_BRACED;
            L_PARENS:  tpl_len = LEN_BRACED;
            L_HEXVALS: tpl_len = LEN_HEXVALS;
            L_WORDS:   tpl_len = LEN_WORDS;
            default:   tpl_len = 7'd0;
        endcase
    endfunction

    // expected character of layout k at position p, C_HEX for a digit slot
    function automatic logic [7:0] tpl_char(input t_layout k, input logic [6:0] p);
        logic [7:0] ch;
        ch = C_HEX;
        case (k)
            L_DIGITS: begin
                ch = C_HEX;
            end
            L_HYPHENS: begin
                case (p)
                    7'd8, 7'd13, 7'd18, 7'd23: ch = C_HYPHEN;
                    default:                   ch = C_HEX;
                endcase
            end
            L_BRACES, L_PARENS: begin
                case (p)
                    7'd0:                      ch = (k == L_BRACES) ? C_LBRACE : C_LPAREN;
                    7'd37:                     ch = (k == L_BRACES) ? C_RBRACE : C_RPAREN;
                    7'd9, 7'd14, 7'd19, 7'd24: ch = C_HYPHEN;
                    default:                   ch = C_HEX;
                endcase
            end
            L_HEXVALS: begin
                case (p)
                    7'd0, 7'd26:  ch = C_LBRACE;
                    7'd66, 7'd67: ch = C_RBRACE;
                    7'd1, 7'd12, 7'd19, 7'd27, 7'd32, 7'd37,
                    7'd42, 7'd47, 7'd52, 7'd57, 7'd62: ch = C_ZERO;
                    7'd2, 7'd13, 7'd20, 7'd28, 7'd33, 7'd38,
                    7'd43, 7'd48, 7'd53, 7'd58, 7'd63: ch = C_X;
                    7'd11, 7'd18, 7'd25, 7'd31, 7'd36,
                    7'd41, 7'd46, 7'd51, 7'd56, 7'd61: ch = C_COMMA;
                    default:                           ch = C_HEX;
                endcase
            end
            L_WORDS: begin
                case (p)
                    7'd8, 7'd17, 7'd26: ch = C_HYPHEN;
                    default:            ch = C_HEX;
                endcase
            end
            default: begin
                ch = C_HEX;
            end
        endcase
        tpl_char = ch;
    endfunction

endpackage

// ===== rtl/gtp_if.sv =====
// ----------------------------------------------------------------------------
// gtp_in_if / gtp_out_if
// valid/ready channels for characters in and parse results out
// ----------------------------------------------------------------------------
interface gtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface gtp_out_if;
    logic              valid;
    logic              ready;
    logic              ok;
    gtp_pkg::t_layout  layout;
    logic [31:0]       word_a;
    logic [31:0]       word_b;
    logic [31:0]       word_c;
    logic [31:0]       word_d;

    modport source (output valid, output ok, output layout, output word_a,
                    output word_b, output word_c, output word_d, input ready);
    modport sink   (input valid, input ok, input layout, input word_a,
                    input word_b, input word_c, input word_d, output ready);
endinterface

// ===== rtl/guid_text_parser_top.sv =====
// ----------------------------------------------------------------------------
// guid_text_parser_top
// streaming GUID text parser, all six layouts checked side by side
// ----------------------------------------------------------------------------
// i_in carries one ASCII character per request with is_last marking the end
// of a string. o_out carries one result per string: ok, the layout code and
// the 128-bit value as word_a..word_d, most significant digit first. A
// failed string gives ok = 0 with layout and words all zero.
// Each character is checked against every layout template and shifted into
// the digit accumulators in the cycle it is accepted, so the block takes one
// character per cycle while i_in.ready is high. The single output register
// drives o_out in the cycle after the last character is accepted.
// i_in.ready is high while the output register is empty or being drained,
// so a stalled receiver holds back the next character only once a result
// is waiting. Synchronous reset clears the position, the layout flags and
// the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "guid_text_parser_top_assert.svh"

module guid_text_parser_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gtp_in_if.sink           i_in,
    gtp_out_if.source        o_out
);
    import gtp_pkg::*;

    logic [6:0]    r_pos;
    logic [6:0]    n_pos;
    t_layout_mask  r_still;
    t_layout_mask  n_still;
    t_acc          r_acc_any;
    t_acc          n_acc_any;
    t_acc          r_acc_hexval;
    t_acc          n_acc_hexval;

    logic          r_out_valid;
    logic          r_out_ok;
    t_layout       r_out_layout;
    t_acc          r_out_value;

    logic          accept;
    logic          char_hex;
    logic [3:0]    char_val;
    t_layout_mask  miss;
    logic [6:0]    str_len;
    t_layout       pick;
    logic          pick_valid;
    logic          res_ok;
    t_acc          res_value;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        logic [7:0] exp_ch;
        logic       match;
        t_layout    lk;
        char_hex = is_hex(i_in.char_code);
        char_val = char_hex ? hex_val(i_in.char_code) : 4'd0;

        for (int k = 0; k < NUM_LAYOUTS; k++) begin
            lk      = t_layout'(3'(k));
            exp_ch  = tpl_char(lk, r_pos);
            match   = (exp_ch == C_HEX) ? char_hex : (i_in.char_code == exp_ch);
            miss[k] = (r_pos < tpl_len(lk)) && !match;
        end
        n_still = r_still & ~miss;

        // separators of the non hex-values layouts are never hex digits
        n_acc_any = char_hex ? {r_acc_any[123:0], char_val} : r_acc_any;

        if ((r_pos < LEN_HEXVALS) && (tpl_char(L_HEXVALS, r_pos) == C_HEX)) begin
            n_acc_hexval = {r_acc_hexval[123:0], char_val};
        end else begin
            n_acc_hexval = r_acc_hexval;
        end

        n_pos   = (r_pos < POS_SAT) ? (r_pos + 7'd1) : r_pos;
        str_len = r_pos + 7'd1;

        pick_valid = 1'b1;
        case (str_len)
            LEN_DIGITS:  pick = L_DIGITS;
            LEN_HYPHENS: pick = L_HYPHENS;
            LEN_BRACED:  pick = n_still[L_BRACES] ? L_BRACES : L_PARENS;
            LEN_HEXVALS: pick = L_HEXVALS;
            LEN_WORDS:   pick = L_WORDS;
            default: begin
                pick       = L_DIGITS;
                pick_valid = 1'b0;
            end
        endcase

        res_ok = pick_valid && n_still[pick];
        if (!res_ok) begin
            res_value = '0;
        end else if (pick == L_HEXVALS) begin
            res_value = n_acc_hexval;
        end else begin
            res_value = n_acc_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_still <= '1;
        end else if (accept) begin
            if (i_in.is_last) begin
                r_pos   <= '0;
                r_still <= '1;
            end else begin
                r_pos   <= n_pos;
                r_still <= n_still;
            end
        end
    end

    // digit accumulators are fully refilled by every string that parses
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc_any    <= n_acc_any;
            r_acc_hexval <= n_acc_hexval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_in.is_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in.is_last) begin
            r_out_ok     <= res_ok;
            r_out_layout <= res_ok ? pick : L_DIGITS;
            r_out_value  <= res_value;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.ok     = r_out_ok;
    assign o_out.layout = r_out_layout;
    assign o_out.word_a = r_out_value[127:96];
    assign o_out.word_b = r_out_value[95:64];
    assign o_out.word_c = r_out_value[63:32];
    assign o_out.word_d = r_out_value[31:0];

    `GTP_ASSERT(a_pos_sat, i_clk, i_rst_n, r_pos <= POS_SAT, "position past saturation")
    `GTP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, accept && i_in.is_last,
        r_out_valid && (r_pos == 7'd0) && (r_still == '1), "last request did not finish string")
    `GTP_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, r_out_valid && !r_out_ok,
        (r_out_layout == L_DIGITS) && (r_out_value == '0), "failed result not cleared")
    `GTP_ASSERT_NEXT(a_midstring_pos, i_clk, i_rst_n, accept && !i_in.is_last,
        r_pos != 7'd0, "position did not advance")

endmodule
